// File: sv/fnsf_pkg.sv
package fnsf_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int LEVEL_W        = 4;
    localparam int GLYPH_W        = 7;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int THRESH_W       = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd30;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd20;
    localparam logic [THRESH_W-1:0]       THRESHOLD_RST    = 4'd1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd9;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [LEVEL_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] pixel_out;
        logic [GLYPH_W-1:0] glyph;
        logic               end_of_frame;
    } t_out_item;

    // one ring entry: original level above, corrected level below
    typedef struct packed {
        logic [LEVEL_W-1:0] orig;
        logic [LEVEL_W-1:0] corr;
    } t_ring_word;

    typedef struct packed {
        logic               emit;
        logic               wen;
        logic               interior;
        logic               eof;
        logic               drain;
        logic [LEVEL_W-1:0] pixel;
    } t_s1_ctrl;

    function automatic logic [GLYPH_W-1:0] level_glyph(input logic [LEVEL_W-1:0] lv);
        logic [GLYPH_W-1:0] g;
        unique case (lv)
            4'd0:    g = 7'h20;
            4'd1:    g = 7'h2E;
            4'd2:    g = 7'h27;
            4'd3:    g = 7'h3A;
            4'd4:    g = 7'h7E;
            4'd5:    g = 7'h2A;
            4'd6:    g = 7'h3D;
            4'd7:    g = 7'h26;
            4'd8:    g = 7'h25;
            default: g = 7'h23;
        endcase
        return g;
    endfunction

endpackage

// File: sv/fnsf_ram.sv
module fnsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// File: sv/fnsf_ctrl.sv
module fnsf_ctrl
    import fnsf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int CW = (AW + 1 > FRAME_WIDTH_W) ? AW + 1 : FRAME_WIDTH_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_s1_adv,
    output logic                  o_s1_valid,
    output t_s1_ctrl              o_s1,
    output logic [AW-1:0]         o_s1_addr,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr_a,
    output logic [AW-1:0]         o_rd_addr_b,
    output logic [THRESH_W-1:0]   o_threshold
);

    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [THRESH_W-1:0]       r_threshold;
    logic [AW-1:0]             r_col;
    logic [FRAME_HEIGHT_W-1:0] r_row;
    logic [CW-1:0]             r_drain_rem;
    logic                      r_s1_valid;
    t_s1_ctrl                  r_s1;
    logic [AW-1:0]             r_s1_addr;

    logic [CW-1:0]             fw_ext;
    logic [CW-1:0]             eff_w;
    logic [FRAME_HEIGHT_W-1:0] eff_h;
    logic [FRAME_HEIGHT_W-1:0] n_row;
    logic                      last_col;
    logic                      in_fire;
    logic                      is_drain;
    logic                      drain_ok;
    logic [AW-1:0]             drain_idx;
    logic [AW-1:0]             right_addr;
    logic [LEVEL_W-1:0]        pix_sat;
    t_s1_ctrl                  n_s1;

    always_comb begin
        fw_ext = CW'(r_frame_width);
        if (fw_ext < CW'(3)) begin
            eff_w = CW'(3);
        end else if (fw_ext > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        eff_h = (r_frame_height < FRAME_HEIGHT_W'(3)) ? FRAME_HEIGHT_W'(3) : r_frame_height;
    end

    assign n_row      = r_row + FRAME_HEIGHT_W'(1);
    assign last_col   = (CW'(r_col) == eff_w - CW'(1));
    assign o_in_ready = !r_s1_valid || i_s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_drain   = (i_in_data.opcode == OP_DRAIN);
    assign drain_ok   = (r_drain_rem != '0) && (r_drain_rem <= eff_w);
    assign drain_idx  = AW'(eff_w - r_drain_rem);
    assign right_addr = (r_col == AW'(MAX_WIDTH - 1)) ? '0 : r_col + AW'(1);
    assign pix_sat    = (i_in_data.pixel_in > LEVEL_MAX) ? LEVEL_MAX : i_in_data.pixel_in;

    always_comb begin
        n_s1.emit     = is_drain ? drain_ok : (r_row != '0);
        n_s1.wen      = !is_drain;
        n_s1.interior = !is_drain && (r_row >= FRAME_HEIGHT_W'(2)) && (r_col != '0) && !last_col;
        n_s1.eof      = is_drain && (r_drain_rem == CW'(1));
        n_s1.drain    = is_drain;
        n_s1.pixel    = pix_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_threshold    <= THRESHOLD_RST;
            r_col          <= '0;
            r_row          <= '0;
            r_drain_rem    <= '0;
            r_s1_valid     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[FRAME_WIDTH_W-1:0];
                        r_col         <= '0;
                        r_row         <= '0;
                        r_drain_rem   <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                        r_col          <= '0;
                        r_row          <= '0;
                        r_drain_rem    <= '0;
                    end
                    CFG_THRESHOLD: begin
                        r_threshold <= i_cfg_data[THRESH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (in_fire) begin
                if (is_drain) begin
                    if (drain_ok) begin
                        r_drain_rem <= r_drain_rem - CW'(1);
                    end
                end else begin
                    r_drain_rem <= '0;
                    if (last_col) begin
                        r_col <= '0;
                        if (n_row >= eff_h) begin
                            r_row       <= '0;
                            r_drain_rem <= eff_w;
                        end else begin
                            r_row <= n_row;
                        end
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1      <= n_s1;
            r_s1_addr <= r_col;
        end
    end

    assign o_s1_valid  = r_s1_valid;
    assign o_s1        = r_s1;
    assign o_s1_addr   = r_s1_addr;
    assign o_rd_en     = in_fire;
    assign o_rd_addr_a = is_drain ? drain_idx : r_col;
    assign o_rd_addr_b = right_addr;
    assign o_threshold = r_threshold;

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_col) < eff_w)
        else $error("column count beyond frame width");

    a_drain_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !is_drain && !i_cfg_we && last_col && (n_row >= eff_h))
        |=> (r_drain_rem == $past(eff_w)) && (r_row == '0))
        else $error("last row drain not armed at end of frame");

endmodule

// File: sv/fnsf_calc.sv
module fnsf_calc
    import fnsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s1_valid,
    input  t_s1_ctrl            i_s1,
    input  t_ring_word          i_rd_a,
    input  t_ring_word          i_rd_b,
    input  logic [THRESH_W-1:0] i_threshold,
    output logic                o_s1_adv,
    output logic                o_wr_en,
    output t_ring_word          o_wr_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    logic [LEVEL_W-1:0] r_left;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [LEVEL_W-1:0] up;
    logic [LEVEL_W-1:0] right;
    logic [LEVEL_W-1:0] down;
    logic [LEVEL_W-1:0] centre;
    logic [LEVEL_W+1:0] nb_sum;
    logic               speckle;
    logic [LEVEL_W-1:0] v;
    logic               s1_fire;

    function automatic logic differs(input logic [LEVEL_W-1:0] nb,
                                     input logic [LEVEL_W-1:0] p,
                                     input logic [THRESH_W-1:0] thr);
        logic [LEVEL_W-1:0] d;
        d = (nb > p) ? nb - p : p - nb;
        return d > thr;
    endfunction

    always_comb begin
        centre  = i_rd_a.orig;
        up      = i_rd_a.corr;
        right   = i_rd_b.orig;
        down    = i_s1.pixel;
        nb_sum  = (LEVEL_W+2)'(up) + (LEVEL_W+2)'(r_left)
                + (LEVEL_W+2)'(right) + (LEVEL_W+2)'(down);
        speckle = differs(up, centre, i_threshold) && differs(r_left, centre, i_threshold)
               && differs(right, centre, i_threshold) && differs(down, centre, i_threshold);
        v       = (i_s1.interior && speckle) ? nb_sum[LEVEL_W+1:2] : centre;
    end

    assign o_s1_adv       = !r_out_valid || i_out_ready;
    assign s1_fire        = i_s1_valid && o_s1_adv;
    assign o_wr_en        = s1_fire && i_s1.wen;
    assign o_wr_data.orig = i_s1.pixel;
    assign o_wr_data.corr = v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_fire && i_s1.emit && !i_s1.drain) begin
                r_left <= v;
            end
            if (o_s1_adv) begin
                r_out_valid <= i_s1_valid && i_s1.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_adv) begin
            r_out.pixel_out    <= v;
            r_out.glyph        <= level_glyph(v);
            r_out.end_of_frame <= i_s1.eof;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && i_s1.emit) |=> o_out_valid)
        else $error("pixel result lost between stage and output register");

endmodule

// File: sv/four_neighbour_speckle_filter.sv
// Four-neighbour speckle filter for a raster stream of gray levels 0..9. It takes one transaction
// per clock, sustained while the output is taken, whether pixel or drain: the row ring is a
// single memory with two registered read ports and one write port, read when a transaction is
// accepted and written back as it leaves stage one, so reads and write never meet on the same
// entry. A pixel of row r gives the corrected pixel of row r-1 at the same column; the first row
// gives nothing, and after the last pixel of a frame one drain transaction per pixel flushes the
// last row, end_of_frame marking its final pixel. Results pass stage one and an output register.
// The ring has no reset or clearing pass and needs none. The user must write configuration
// only while the block is idle, which it does not enforce; a size write restarts the frame.
module four_neighbour_speckle_filter
    import fnsf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                s1_adv;
    logic                s1_valid;
    t_s1_ctrl            s1;
    logic [AW-1:0]       s1_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr_a;
    logic [AW-1:0]       rd_addr_b;
    logic [THRESH_W-1:0] threshold;
    t_ring_word          rd_a;
    t_ring_word          rd_b;
    logic                wr_en;
    t_ring_word          wr_data;

    fnsf_ctrl #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_s1_adv    (s1_adv),
        .o_s1_valid  (s1_valid),
        .o_s1        (s1),
        .o_s1_addr   (s1_addr),
        .o_rd_en     (rd_en),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_threshold (threshold)
    );

    fnsf_ram #(
        .WIDTH($bits(t_ring_word)),
        .DEPTH(MAX_WIDTH)
    ) u_ring (
        .i_clk       (i_clk),
        .i_we        (wr_en),
        .i_wr_addr   (s1_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    fnsf_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_rd_a      (rd_a),
        .i_rd_b      (rd_b),
        .i_threshold (threshold),
        .o_s1_adv    (s1_adv),
        .o_wr_en     (wr_en),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: test/testbench.sv
module testbench;
    import fnsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_CYCLES = 8;
    localparam int STUCK_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int SCHED_N      = 5;
    localparam int MAX_REPORTS  = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // glyphs for levels 0..9, level 0 in the top byte
    localparam bit [79:0] LEVEL_CHARS = " .':~*=&%#";

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              item;
        bit                    typed;
        t_out_item             want;
    } t_script_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    four_neighbour_speckle_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // filter state mirrored on the testbench side
    logic [LEVEL_W-1:0]        orig_row [MAX_W];
    logic [LEVEL_W-1:0]        corr_row [MAX_W];
    int unsigned               col_cnt;
    int unsigned               row_cnt;
    int unsigned               drain_left;
    logic [LEVEL_W-1:0]        left_corr;
    logic [FRAME_WIDTH_W-1:0]  cfg_width;
    logic [FRAME_HEIGHT_W-1:0] cfg_height;
    logic [THRESH_W-1:0]       cfg_thresh;

    t_out_item   pending_pixels [$];
    t_script_row script [$];
    t_idle_mode  idle_mode = IDLE_NONE;
    int unsigned mismatches = 0;
    int unsigned stuck_cycles = 0;
    t_out_item   oldest;

    function automatic int unsigned frame_cols();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned frame_rows();
        return (cfg_height < 3) ? 3 : cfg_height;
    endfunction

    function automatic void restart_frame();
        col_cnt    = 0;
        row_cnt    = 0;
        drain_left = 0;
        left_corr  = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_WIDTH: begin
                cfg_width = data[FRAME_WIDTH_W-1:0];
                restart_frame();
            end
            CFG_FRAME_HEIGHT: begin
                cfg_height = data[FRAME_HEIGHT_W-1:0];
                restart_frame();
            end
            CFG_THRESHOLD: cfg_thresh = data[THRESH_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic bit far_apart(input logic [LEVEL_W-1:0] a, input logic [LEVEL_W-1:0] b);
        int d;
        d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
        return d > int'(cfg_thresh);
    endfunction

    function automatic t_out_item level_result(input logic [LEVEL_W-1:0] lv, input logic eof);
        t_out_item r;
        logic [7:0] ch;
        ch = LEVEL_CHARS[79 - 8 * int'(lv) -: 8];
        r.pixel_out    = lv;
        r.glyph        = ch[GLYPH_W-1:0];
        r.end_of_frame = eof;
        return r;
    endfunction

    // one transaction through the in-place filter; returns 1 when a pixel leaves
    function automatic bit filter_transaction(input t_in_item it, output t_out_item res);
        int unsigned w, h, c, er, idx, sum;
        logic [LEVEL_W-1:0] p, v, up, rt;
        bit got;
        w   = frame_cols();
        h   = frame_rows();
        res = '0;
        got = 1'b0;
        if (it.opcode == OP_DRAIN) begin
            if (drain_left == 0 || drain_left > w) return 1'b0;
            idx = w - drain_left;
            drain_left--;
            res = level_result(orig_row[idx], drain_left == 0);
            return 1'b1;
        end
        p = (it.pixel_in > LEVEL_MAX) ? LEVEL_MAX : it.pixel_in;
        c = col_cnt;
        drain_left = 0;
        if (row_cnt >= 1) begin
            er = row_cnt - 1;
            v  = orig_row[c];
            if (er != 0 && er != h - 1 && c != 0 && c != w - 1) begin
                up = corr_row[c];
                rt = orig_row[(c + 1) % MAX_W];
                if (far_apart(up, v) && far_apart(left_corr, v) && far_apart(rt, v) &&
                    far_apart(p, v)) begin
                    sum = up + left_corr + rt + p;
                    v   = LEVEL_W'(sum / 4);
                end
            end
            corr_row[c] = v;
            left_corr   = v;
            res = level_result(v, 1'b0);
            got = 1'b1;
        end
        orig_row[c] = p;
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h) begin
                row_cnt    = 0;
                drain_left = w;
            end
        end
        return got;
    endfunction

    function automatic bit sender_idle();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:   return $urandom_range(0, 99) < 31;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 84;
            IDLE_BOTH:     return $urandom_range(0, 99) < 31;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic t_script_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        t_script_row r;
        r = '{is_cfg: 1'b1, idx: idx, data: data, item: '0, typed: 1'b0, want: '0};
        return r;
    endfunction

    function automatic t_script_row txn_row(input logic op, input logic [LEVEL_W-1:0] lv,
                                            input bit typed = 1'b0,
                                            input logic [LEVEL_W-1:0] out_lv = '0,
                                            input logic [GLYPH_W-1:0] out_glyph = '0,
                                            input logic out_eof = 1'b0);
        t_script_row r;
        r.is_cfg = 1'b0;
        r.idx    = '0;
        r.data   = '0;
        r.item   = '{opcode: op, pixel_in: lv};
        r.typed  = typed;
        r.want   = '{pixel_out: out_lv, glyph: out_glyph, end_of_frame: out_eof};
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_out_item want, input t_out_item got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected pixel %0d glyph %h eof %0d, got pixel %0d glyph %h eof %0d",
                     $realtime, what, want.pixel_out, want.glyph, want.end_of_frame,
                     got.pixel_out, got.glyph, got.end_of_frame);
    endtask

    // hold the input low until every expected pixel has left and the pipe is empty
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drive_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item res;
        bit got;
        if (sender_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (sender_idle()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        got = filter_transaction(it, res);
        if (typed)
            pending_pixels.push_back(want);
        else if (got)
            pending_pixels.push_back(res);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= !receiver_stall();
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                note_mismatch("unexpected transaction", '0, o_out_data);
            end else begin
                oldest = pending_pixels.pop_front();
                if (o_out_data.pixel_out !== oldest.pixel_out ||
                    o_out_data.glyph !== oldest.glyph ||
                    o_out_data.end_of_frame !== oldest.end_of_frame)
                    note_mismatch("mismatch", oldest, o_out_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned ep, w, h, total, n_pix, n_drain, base, small_items, r, cap;
        int lv;
        bit full;
        logic [CFG_DATA_W-1:0] wd, hd, td;
        t_in_item it;

        foreach (orig_row[k]) begin
            orig_row[k] = '0;
            corr_row[k] = '0;
        end
        cfg_width  = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        cfg_thresh = THRESHOLD_RST;
        restart_frame();

        // 3x3 frame with saturated borders and a centre spike, then a drain flush
        script.push_back(reg_row(CFG_FRAME_WIDTH, 16'd3));
        script.push_back(reg_row(CFG_FRAME_HEIGHT, 16'd3));
        script.push_back(txn_row(OP_PIXEL, 4'd15));
        script.push_back(txn_row(OP_PIXEL, 4'd0));
        script.push_back(txn_row(OP_PIXEL, 4'd12));
        script.push_back(txn_row(OP_PIXEL, 4'd0, 1'b1, 4'd9, 7'h23, 1'b0));
        script.push_back(txn_row(OP_PIXEL, 4'd9, 1'b1, 4'd0, 7'h20, 1'b0));
        script.push_back(txn_row(OP_PIXEL, 4'd0, 1'b1, 4'd9, 7'h23, 1'b0));
        script.push_back(txn_row(OP_PIXEL, 4'd9, 1'b1, 4'd0, 7'h20, 1'b0));
        script.push_back(txn_row(OP_PIXEL, 4'd0, 1'b1, 4'd0, 7'h20, 1'b0));
        script.push_back(txn_row(OP_PIXEL, 4'd15, 1'b1, 4'd0, 7'h20, 1'b0));
        script.push_back(txn_row(OP_DRAIN, 4'd15, 1'b1, 4'd9, 7'h23, 1'b0));
        script.push_back(txn_row(OP_DRAIN, 4'd0, 1'b1, 4'd0, 7'h20, 1'b0));
        script.push_back(txn_row(OP_DRAIN, 4'd10, 1'b1, 4'd9, 7'h23, 1'b1));
        // nothing left to drain
        script.push_back(txn_row(OP_DRAIN, 4'd5));
        // speckle replaced by a non-trivial mean, then a pixel cuts the drain short
        script.push_back(txn_row(OP_PIXEL, 4'd2));
        script.push_back(txn_row(OP_PIXEL, 4'd4));
        script.push_back(txn_row(OP_PIXEL, 4'd6));
        script.push_back(txn_row(OP_PIXEL, 4'd3));
        script.push_back(txn_row(OP_PIXEL, 4'd0));
        script.push_back(txn_row(OP_PIXEL, 4'd7));
        script.push_back(txn_row(OP_PIXEL, 4'd8));
        script.push_back(txn_row(OP_PIXEL, 4'd5));
        script.push_back(txn_row(OP_PIXEL, 4'd1));
        script.push_back(txn_row(OP_DRAIN, 4'd3));
        script.push_back(txn_row(OP_PIXEL, 4'd7));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                wait_quiet();
                write_reg(script[k].idx, script[k].data);
            end else begin
                drive_item(script[k].item, script[k].typed, script[k].want);
            end
        end

        ep = 0;
        small_items = 0;
        while (ep < SCHED_N || small_items < RANDOM_ITEMS) begin
            idle_mode = t_idle_mode'(ep % 4);
            if (ep < SCHED_N) begin
                case (ep)
                    0: begin wd = 16'd0;    hd = 16'd0;    td = 16'd0;  full = 1'b1; end
                    1: begin wd = 16'd2;    hd = 16'd2;    td = 16'd9;  full = 1'b1; end
                    2: begin wd = 16'd5;    hd = 16'hFFFF; td = 16'd15; full = 1'b0; end
                    3: begin wd = 16'hFFFF; hd = 16'd3;    td = 16'd1;  full = 1'b0; end
                    default: begin wd = 16'd1024; hd = 16'd1; td = 16'd2; full = 1'b0; end
                endcase
                wait_quiet();
                if (ep == 0) write_reg(CFG_UNUSED, 16'hFFFF);
                write_reg(CFG_FRAME_WIDTH, wd);
                write_reg(CFG_FRAME_HEIGHT, hd);
                write_reg(CFG_THRESHOLD, td);
            end else begin
                full = $urandom_range(0, 99) < 80;
                if ($urandom_range(0, 99) < 60) begin
                    wait_quiet();
                    if ($urandom_range(0, 99) < 70)
                        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 2) : $urandom_range(3, 12)));
                    if ($urandom_range(0, 99) < 70)
                        write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, 2) : $urandom_range(3, 7)));
                    if ($urandom_range(0, 99) < 70)
                        write_reg(CFG_THRESHOLD, CFG_DATA_W'(($urandom_range(0, 4) == 0) ?
                                  $urandom_range(0, 15) : $urandom_range(0, 3)));
                end
            end

            w     = frame_cols();
            h     = frame_rows();
            total = w * h;
            cap   = (total - 1 < 2 * w + 40) ? total - 1 : 2 * w + 40;
            // wide frames: just into the second row
            if (w > 64) cap = w + 8;
            n_pix = full ? total : $urandom_range(1, cap);
            base  = $urandom_range(0, 9);

            // smooth background with scattered spikes and out-of-range levels
            repeat (n_pix) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    lv = int'(base) + int'($urandom_range(0, 2)) - 1;
                    if (lv < 0) lv = 0;
                    if (lv > 9) lv = 9;
                end else if (r < 95) begin
                    lv = $urandom_range(0, 9);
                end else begin
                    lv = $urandom_range(10, 15);
                end
                it = '{opcode: OP_PIXEL, pixel_in: LEVEL_W'(lv)};
                drive_item(it, 1'b0, '0);
                small_items++;
            end

            r = $urandom_range(0, 99);
            if (!full)
                n_drain = $urandom_range(0, 2);
            else if (r < 70)
                n_drain = w;
            else if (r < 85)
                n_drain = $urandom_range(0, w - 1);
            else
                n_drain = w + $urandom_range(1, 3);
            repeat (n_drain) begin
                it = '{opcode: OP_DRAIN, pixel_in: LEVEL_W'($urandom_range(0, 15))};
                drive_item(it, 1'b0, '0);
                small_items++;
            end
            ep++;
        end

        idle_mode = IDLE_NONE;
        wait_quiet();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
sv/fnsf_pkg.sv
sv/fnsf_ram.sv
sv/fnsf_ctrl.sv
sv/fnsf_calc.sv
sv/four_neighbour_speckle_filter.sv
test/testbench.sv
